// File: hdl/segx_pkg.sv
`timescale 1ns / 1ps
package segx_pkg;

    localparam int CW   = 16;
    localparam int FW   = 8;
    localparam int OW   = 24;
    localparam int DXW  = CW + 1;
    localparam int PDW  = 2 * DXW;
    localparam int DW   = PDW + 1;
    localparam int PPW  = 2 * CW;
    localparam int PRW  = PPW + 1;
    localparam int MW   = PRW + DXW;
    localparam int NXW  = MW + 1;
    localparam int QW   = OW;
    localparam int NMW  = NXW + FW;
    localparam int RW   = DW + QW;
    localparam int SQW  = QW + 1;

    typedef struct packed {
        logic signed [CW-1:0] seg1_start_x;
        logic signed [CW-1:0] seg1_start_y;
        logic signed [CW-1:0] seg1_end_x;
        logic signed [CW-1:0] seg1_end_y;
        logic signed [CW-1:0] seg2_start_x;
        logic signed [CW-1:0] seg2_start_y;
        logic signed [CW-1:0] seg2_end_x;
        logic signed [CW-1:0] seg2_end_y;
    } seg_t;

    typedef struct packed {
        logic                 hit;
        logic signed [OW-1:0] cross_x;
        logic signed [OW-1:0] cross_y;
    } res_t;

    typedef struct packed {
        logic signed [CW-1:0] lox1;
        logic signed [CW-1:0] hix1;
        logic signed [CW-1:0] lox2;
        logic signed [CW-1:0] hix2;
        logic signed [CW-1:0] loy1;
        logic signed [CW-1:0] hiy1;
        logic signed [CW-1:0] loy2;
        logic signed [CW-1:0] hiy2;
    } bnd_t;

    typedef struct packed {
        logic negx;
        logic negy;
        logic miss;
        bnd_t bnd;
    } side_t;

endpackage

// File: hdl/segx_div.sv
`timescale 1ns / 1ps
module segx_div (
    input  logic                     clk,
    input  logic                     en,
    input  logic [segx_pkg::RW-1:0]  num,
    input  logic [segx_pkg::DW-1:0]  den,
    output logic [segx_pkg::QW-1:0]  quo
);
    import segx_pkg::*;

    logic [RW-1:0] r_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [QW-1:0] q_reg [QW];

    logic [RW-1:0] r_in [QW];
    logic [DW-1:0] d_in [QW];
    logic [QW-1:0] q_in [QW];
    logic [RW-1:0] r_next [QW];
    logic [QW-1:0] q_next [QW];

    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            logic [RW-1:0] t;
            if (i == 0)
            begin
                r_in[i] = num;
                d_in[i] = den;
                q_in[i] = '0;
            end
            else
            begin
                r_in[i] = r_reg[i-1];
                d_in[i] = d_reg[i-1];
                q_in[i] = q_reg[i-1];
            end
            t = RW'(d_in[i]) << (QW - 1 - i);
            if (r_in[i] >= t)
            begin
                r_next[i] = r_in[i] - t;
                q_next[i] = {q_in[i][QW-2:0], 1'b1};
            end
            else
            begin
                r_next[i] = r_in[i];
                q_next[i] = {q_in[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                r_reg[i] <= r_next[i];
                d_reg[i] <= d_in[i];
                q_reg[i] <= q_next[i];
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// File: hdl/segment_intersection_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// seg      in         seg_valid, seg_ready   seg (seg_t, two segments)
// res      out        res_valid, res_ready   res (res_t, hit and crossing point)
//
// One item is accepted per cycle while the output register is empty or res_ready is high;
// each result passes through every stage below into the output register.
// The pipeline consists of seven arithmetic stages, a 24-stage restoring divider
// and the output register.
// Reset clears all valid bits; data registers are not reset.
// A stalled output register freezes the whole pipeline, so nothing is lost.
module segment_intersection_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seg_valid,
    output logic            seg_ready,
    input  segx_pkg::seg_t  seg,
    output logic            res_valid,
    input  logic            res_ready,
    output segx_pkg::res_t  res
);
    import segx_pkg::*;

    logic en;
    logic [5:0] v_reg;

    seg_t c1_reg;
    logic signed [DXW-1:0] dx12_1_reg, dy12_1_reg, dx34_1_reg, dy34_1_reg;
    bnd_t b1_reg;
    bnd_t b_next;

    logic signed [PDW-1:0] pd1_reg, pd2_reg;
    logic signed [PPW-1:0] pp1_reg, pp2_reg, pq1_reg, pq2_reg;
    logic signed [DXW-1:0] dx12_2_reg, dy12_2_reg, dx34_2_reg, dy34_2_reg;
    bnd_t b2_reg;

    logic signed [DW-1:0]  d3_reg;
    logic signed [PRW-1:0] pre_reg, post_reg;
    logic signed [DXW-1:0] dx12_3_reg, dy12_3_reg, dx34_3_reg, dy34_3_reg;
    bnd_t b3_reg;

    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [DW-1:0] d4_reg;
    bnd_t b4_reg;

    logic signed [NXW-1:0] nx_reg, ny_reg;
    logic signed [DW-1:0]  d5_reg;
    bnd_t b5_reg;

    logic [NMW-1:0] nmx_reg, nmy_reg;
    logic [DW-1:0]  dm6_reg;
    logic           negx6_reg, negy6_reg, dz6_reg;
    bnd_t b6_reg;
    logic [NXW-1:0] magx, magy;

    logic [RW-1:0] nx7_reg, ny7_reg;
    logic [DW-1:0] dm7_reg;
    side_t s7_reg;
    logic  s7_valid_reg;

    side_t sd_reg [QW];
    logic [QW-1:0] sd_valid_reg;
    logic [QW-1:0] qx, qy;

    res_t res_reg, res_next;
    logic res_valid_reg;

    assign en = !res_valid_reg || res_ready;
    assign seg_ready = en;

    always_comb
    begin
        b_next.lox1 = (seg.seg1_start_x < seg.seg1_end_x) ? seg.seg1_start_x : seg.seg1_end_x;
        b_next.hix1 = (seg.seg1_start_x < seg.seg1_end_x) ? seg.seg1_end_x : seg.seg1_start_x;
        b_next.lox2 = (seg.seg2_start_x < seg.seg2_end_x) ? seg.seg2_start_x : seg.seg2_end_x;
        b_next.hix2 = (seg.seg2_start_x < seg.seg2_end_x) ? seg.seg2_end_x : seg.seg2_start_x;
        b_next.loy1 = (seg.seg1_start_y < seg.seg1_end_y) ? seg.seg1_start_y : seg.seg1_end_y;
        b_next.hiy1 = (seg.seg1_start_y < seg.seg1_end_y) ? seg.seg1_end_y : seg.seg1_start_y;
        b_next.loy2 = (seg.seg2_start_y < seg.seg2_end_y) ? seg.seg2_start_y : seg.seg2_end_y;
        b_next.hiy2 = (seg.seg2_start_y < seg.seg2_end_y) ? seg.seg2_end_y : seg.seg2_start_y;
    end

    assign magx = nx_reg[NXW-1] ? NXW'(-nx_reg) : NXW'(nx_reg);
    assign magy = ny_reg[NXW-1] ? NXW'(-ny_reg) : NXW'(ny_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            s7_valid_reg <= 1'b0;
            sd_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], seg_valid};
            s7_valid_reg <= v_reg[5];
            sd_valid_reg <= {sd_valid_reg[QW-2:0], s7_valid_reg};
            res_valid_reg <= sd_valid_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg     <= seg;
            dx12_1_reg <= DXW'(seg.seg1_start_x) - DXW'(seg.seg1_end_x);
            dy12_1_reg <= DXW'(seg.seg1_start_y) - DXW'(seg.seg1_end_y);
            dx34_1_reg <= DXW'(seg.seg2_start_x) - DXW'(seg.seg2_end_x);
            dy34_1_reg <= DXW'(seg.seg2_start_y) - DXW'(seg.seg2_end_y);
            b1_reg     <= b_next;

            pd1_reg <= PDW'(dx12_1_reg) * PDW'(dy34_1_reg);
            pd2_reg <= PDW'(dy12_1_reg) * PDW'(dx34_1_reg);
            pp1_reg <= PPW'(c1_reg.seg1_start_x) * PPW'(c1_reg.seg1_end_y);
            pp2_reg <= PPW'(c1_reg.seg1_start_y) * PPW'(c1_reg.seg1_end_x);
            pq1_reg <= PPW'(c1_reg.seg2_start_x) * PPW'(c1_reg.seg2_end_y);
            pq2_reg <= PPW'(c1_reg.seg2_start_y) * PPW'(c1_reg.seg2_end_x);
            dx12_2_reg <= dx12_1_reg;
            dy12_2_reg <= dy12_1_reg;
            dx34_2_reg <= dx34_1_reg;
            dy34_2_reg <= dy34_1_reg;
            b2_reg     <= b1_reg;

            d3_reg   <= DW'(pd1_reg) - DW'(pd2_reg);
            pre_reg  <= PRW'(pp1_reg) - PRW'(pp2_reg);
            post_reg <= PRW'(pq1_reg) - PRW'(pq2_reg);
            dx12_3_reg <= dx12_2_reg;
            dy12_3_reg <= dy12_2_reg;
            dx34_3_reg <= dx34_2_reg;
            dy34_3_reg <= dy34_2_reg;
            b3_reg     <= b2_reg;

            m1_reg <= MW'(pre_reg) * MW'(dx34_3_reg);
            m2_reg <= MW'(dx12_3_reg) * MW'(post_reg);
            m3_reg <= MW'(pre_reg) * MW'(dy34_3_reg);
            m4_reg <= MW'(dy12_3_reg) * MW'(post_reg);
            d4_reg <= d3_reg;
            b4_reg <= b3_reg;

            nx_reg <= NXW'(m1_reg) - NXW'(m2_reg);
            ny_reg <= NXW'(m3_reg) - NXW'(m4_reg);
            d5_reg <= d4_reg;
            b5_reg <= b4_reg;

            nmx_reg   <= {magx, {FW{1'b0}}};
            nmy_reg   <= {magy, {FW{1'b0}}};
            dm6_reg   <= d5_reg[DW-1] ? DW'(-d5_reg) : DW'(d5_reg);
            negx6_reg <= nx_reg[NXW-1] ^ d5_reg[DW-1];
            negy6_reg <= ny_reg[NXW-1] ^ d5_reg[DW-1];
            dz6_reg   <= (d5_reg == '0);
            b6_reg    <= b5_reg;

            nx7_reg     <= RW'(nmx_reg);
            ny7_reg     <= RW'(nmy_reg);
            dm7_reg     <= dm6_reg;
            s7_reg.negx <= negx6_reg;
            s7_reg.negy <= negy6_reg;
            s7_reg.miss <= dz6_reg
                || ({1'b0, RW'(nmx_reg)} >= {dm6_reg, {QW{1'b0}}, 1'b0} >> 1)
                || ({1'b0, RW'(nmy_reg)} >= {dm6_reg, {QW{1'b0}}, 1'b0} >> 1);
            s7_reg.bnd  <= b6_reg;

            sd_reg[0] <= s7_reg;
            for (int i = 1; i < QW; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end

            res_reg <= res_next;
        end
    end

    segx_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (nx7_reg),
        .den (dm7_reg),
        .quo (qx)
    );

    segx_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (ny7_reg),
        .den (dm7_reg),
        .quo (qy)
    );

    always_comb
    begin
        logic signed [SQW-1:0] sx, sy;
        logic signed [SQW-1:0] lx1, hx1, lx2, hx2, ly1, hy1, ly2, hy2;
        logic inside_all;
        side_t s;
        s  = sd_reg[QW-1];
        sx = s.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        sy = s.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        lx1 = SQW'($signed({s.bnd.lox1, {FW{1'b0}}}));
        hx1 = SQW'($signed({s.bnd.hix1, {FW{1'b0}}}));
        lx2 = SQW'($signed({s.bnd.lox2, {FW{1'b0}}}));
        hx2 = SQW'($signed({s.bnd.hix2, {FW{1'b0}}}));
        ly1 = SQW'($signed({s.bnd.loy1, {FW{1'b0}}}));
        hy1 = SQW'($signed({s.bnd.hiy1, {FW{1'b0}}}));
        ly2 = SQW'($signed({s.bnd.loy2, {FW{1'b0}}}));
        hy2 = SQW'($signed({s.bnd.hiy2, {FW{1'b0}}}));
        inside_all = (sx >= lx1) && (sx <= hx1) && (sx >= lx2) && (sx <= hx2)
                  && (sy >= ly1) && (sy <= hy1) && (sy >= ly2) && (sy <= hy2);
        if (!s.miss && inside_all)
        begin
            res_next.hit     = 1'b1;
            res_next.cross_x = sx[OW-1:0];
            res_next.cross_y = sy[OW-1:0];
        end
        else
        begin
            res_next.hit     = 1'b0;
            res_next.cross_x = '0;
            res_next.cross_y = '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hdl/segx_checker.sv
`timescale 1ns / 1ps
module segx_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            seg_ready,
    input logic            res_valid,
    input logic            res_ready,
    input segx_pkg::res_t  res
);
    import segx_pkg::*;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.hit) |-> (res.cross_x == '0 && res.cross_y == '0))
        else $error("miss result carries a nonzero point");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> seg_ready)
        else $error("input stalled while output register is empty");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |-> !seg_ready)
        else $error("item accepted while pipeline is stalled");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result changed");

endmodule

bind segment_intersection_top segx_checker u_segx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_ready (seg_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// File: verif/tb_segment_intersection_top.sv
`timescale 1ns / 1ps
module tb_segment_intersection_top;
    import segx_pkg::*;

    localparam int NUM_RANDOM = 930;
    localparam int PAUSE_AT = 500;

    logic clk;
    logic rst_n;
    logic seg_valid;
    logic seg_ready;
    seg_t seg;
    logic res_valid;
    logic res_ready;
    res_t res;

    seg_t pairs_to_send[$];
    res_t crossings_due[$];
    int   num_accepted = 0;
    int   num_total = 0;
    int   num_errors = 0;
    bit   seg_taken = 1'b0;
    bit   pause_done = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    segment_intersection_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint scaled_quotient(longint num, longint den);
        longint mag_n;
        longint mag_d;
        longint q;
        begin
            mag_n = (num < 0) ? -num : num;
            mag_d = (den < 0) ? -den : den;
            q = (mag_n <<< FW) / mag_d;
            if (q > (longint'(1) <<< 62))
                q = longint'(1) <<< 62;
            return ((num < 0) != (den < 0)) ? -q : q;
        end
    endfunction

    function automatic bit in_span(longint v, longint a, longint b);
        longint lo;
        longint hi;
        begin
            lo = ((a < b) ? a : b) <<< FW;
            hi = ((a < b) ? b : a) <<< FW;
            return (v >= lo) && (v <= hi);
        end
    endfunction

    function automatic res_t predict_crossing(seg_t s);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dx12, dy12, dx34, dy34, det, pre, post, qx, qy;
        res_t r;
        begin
            x1 = s.seg1_start_x;
            y1 = s.seg1_start_y;
            x2 = s.seg1_end_x;
            y2 = s.seg1_end_y;
            x3 = s.seg2_start_x;
            y3 = s.seg2_start_y;
            x4 = s.seg2_end_x;
            y4 = s.seg2_end_y;
            r = '0;
            dx12 = x1 - x2;
            dy12 = y1 - y2;
            dx34 = x3 - x4;
            dy34 = y3 - y4;
            det = dx12 * dy34 - dy12 * dx34;
            if (det == 0)
                return r;
            pre = x1 * y2 - y1 * x2;
            post = x3 * y4 - y3 * x4;
            qx = scaled_quotient(pre * dx34 - dx12 * post, det);
            qy = scaled_quotient(pre * dy34 - dy12 * post, det);
            if (in_span(qx, x1, x2) && in_span(qx, x3, x4)
                && in_span(qy, y1, y2) && in_span(qy, y3, y4))
            begin
                r.hit = 1'b1;
                r.cross_x = qx[OW-1:0];
                r.cross_y = qy[OW-1:0];
            end
            return r;
        end
    endfunction

    function automatic seg_t make_pair(int ax, int ay, int bx, int by,
                                       int cx, int cy, int ex, int ey);
        seg_t s;
        begin
            s.seg1_start_x = ax[CW-1:0];
            s.seg1_start_y = ay[CW-1:0];
            s.seg1_end_x   = bx[CW-1:0];
            s.seg1_end_y   = by[CW-1:0];
            s.seg2_start_x = cx[CW-1:0];
            s.seg2_start_y = cy[CW-1:0];
            s.seg2_end_x   = ex[CW-1:0];
            s.seg2_end_y   = ey[CW-1:0];
            return s;
        end
    endfunction

    function automatic int rand_coord(int span);
        begin
            return int'($urandom_range(2 * span)) - span;
        end
    endfunction

    function automatic seg_t random_pair();
        seg_t s;
        int pick;
        int span;
        int ox;
        int oy;
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                s = seg_t'({$urandom, $urandom, $urandom, $urandom});
            end
            else if (pick < 80)
            begin
                span = (pick < 60) ? 20 : 3000;
                s = make_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                              rand_coord(span), rand_coord(span), rand_coord(span),
                              rand_coord(span), rand_coord(span));
            end
            else if (pick < 90)
            begin
                s = make_pair(rand_coord(500), rand_coord(500), rand_coord(500),
                              rand_coord(500), 0, 0, 0, 0);
                ox = rand_coord(50);
                oy = rand_coord(50);
                s.seg2_start_x = s.seg1_start_x + ox[CW-1:0];
                s.seg2_start_y = s.seg1_start_y + oy[CW-1:0];
                s.seg2_end_x   = s.seg1_end_x + ox[CW-1:0];
                s.seg2_end_y   = s.seg1_end_y + oy[CW-1:0];
            end
            else
            begin
                s = make_pair(rand_coord(32767), rand_coord(32767), rand_coord(32767),
                              rand_coord(32767), 0, 0, 0, 0);
                s.seg2_start_x = s.seg1_start_x;
                s.seg2_start_y = s.seg1_end_y;
                s.seg2_end_x   = s.seg1_end_x;
                s.seg2_end_y   = s.seg1_start_y;
            end
            return s;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && seg_valid && seg_ready)
        begin
            crossings_due.push_back(predict_crossing(seg));
            num_accepted++;
            seg_taken = 1'b1;
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (crossings_due.size() == 0)
            begin
                $error("result without a pending item: hit=%0d x=%0d y=%0d",
                       res.hit, res.cross_x, res.cross_y);
                num_errors++;
            end
            else
            begin
                res_t want;
                want = crossings_due.pop_front();
                if (res.hit !== want.hit)
                begin
                    $error("hit expected %0d actual %0d", want.hit, res.hit);
                    num_errors++;
                end
                if (res.cross_x !== want.cross_x)
                begin
                    $error("cross_x expected %0d actual %0d", want.cross_x, res.cross_x);
                    num_errors++;
                end
                if (res.cross_y !== want.cross_y)
                begin
                    $error("cross_y expected %0d actual %0d", want.cross_y, res.cross_y);
                    num_errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (num_accepted < num_total / 3)
        begin
            send_idle_pct = 27;
            recv_idle_pct = 70;
        end
        else if (num_accepted < 2 * num_total / 3)
        begin
            send_idle_pct = 70;
            recv_idle_pct = 27;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (!rst_n)
        begin
            seg_valid <= 1'b0;
            seg <= '0;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (!seg_valid || seg_taken)
            begin
                seg_taken = 1'b0;
                if (!pause_done && num_accepted == PAUSE_AT && crossings_due.size() != 0)
                begin
                    seg_valid <= 1'b0;
                end
                else if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    if (num_accepted == PAUSE_AT)
                        pause_done = 1'b1;
                    seg <= pairs_to_send.pop_front();
                    seg_valid <= 1'b1;
                end
                else
                begin
                    seg_valid <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;

        pairs_to_send.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pairs_to_send.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        pairs_to_send.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        pairs_to_send.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        pairs_to_send.push_back(make_pair(0, 0, 10, 10, 20, 20, 30, 30));
        pairs_to_send.push_back(make_pair(0, 0, 10, 10, 5, 5, 15, 15));
        pairs_to_send.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
        pairs_to_send.push_back(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
        pairs_to_send.push_back(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
        pairs_to_send.push_back(make_pair(0, 0, -3, -1, 0, -1, -3, 0));
        pairs_to_send.push_back(make_pair(0, 0, 1, 3, 1, 0, 0, 3));
        pairs_to_send.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pairs_to_send.push_back(make_pair(32767, -32768, -32768, 32767,
                                          -32768, -32768, 32767, 32767));
        pairs_to_send.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        pairs_to_send.push_back(make_pair(-32768, -32768, -32768, 32767,
                                          32767, -32768, 32767, 32767));
        pairs_to_send.push_back(make_pair(-32768, -32768, 32767, -32767,
                                          -32768, -32767, 32767, -32768));
        pairs_to_send.push_back(make_pair(32767, 32767, 32766, 32767,
                                          32767, 32766, 32767, 32767));
        pairs_to_send.push_back(make_pair(0, 0, 1, 32767, 1, 0, 0, 32767));
        pairs_to_send.push_back(make_pair(-7, 3, 5, -2, -6, -4, 4, 6));
        pairs_to_send.push_back(make_pair(0, 0, 1, 1000, 1, 1, 0, 999));
        for (int i = 0; i < NUM_RANDOM; i++)
            pairs_to_send.push_back(random_pair());
        num_total = pairs_to_send.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (num_accepted == num_total);
        wait (crossings_due.size() == 0);
        repeat (40) @(posedge clk);
        if (num_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
